// ----- design/stks_pkg.sv -----
// stks_pkg: shared types and constants for the sorted table key search block.
// Holds the sequencer state type, operation and register codes, and field widths.
// No dependencies.
`default_nettype none

package stks_pkg;

    // Input and result field widths
    localparam int ENTRY_INDEX_W = 10;
    localparam int IN_KEY_W      = 32;
    localparam int POS_W         = 11;
    localparam int COUNT_W       = 11;
    localparam int TOL_W         = 16;

    // Stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Search bound width: holds -1 up to the largest count
    localparam int BOUND_W = COUNT_W + 1;

    localparam logic [POS_W-1:0] POS_NONE = '1;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_KEY_COUNT = 2'd0,
        CFG_MATCH_TOL = 2'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ----- design/sorted_table_key_search.sv -----
// sorted_table_key_search: top level, key table memory and binary search sequencer.
// Depends on stks_pkg.
//
// Usage: software writes key_count and match_tolerance over the cfg channel
// (cfg_index 0 and 1), loads ascending keys with s_tuser = 0 (load) items, then
// sends s_tuser = 1 (query) items. Each query gives one result on the m_ channel;
// a load gives none. A key matches an entry when they differ by at most the
// tolerance.
// Flow: a load is accepted in idle and s_tready stays high. A query is accepted
// in idle, probes the table in the search state, and then moves the result into
// the output register; it makes at most floor(log2(key_count)) + 1 probes (11
// for a full 1024 entry table, none for an empty one). The single table read
// port, one registered read per probe, sets the probe rate; s_tready is low while
// a query is searching or waiting to deliver its result.
// The output register holds a finished result while the next item is taken; if
// the receiver stalls, a second finished query waits in its last state until
// the output register frees up.
// Reset clears the configuration registers, the sequencer state and the output
// valid; the table is not cleared and an entry holds no defined value until it is loaded.
`default_nettype none

module sorted_table_key_search #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH   = 32
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // configuration write channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [stks_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [stks_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input stream
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // [9:0] entry_index, [41:10] key_value, [42] miss_as_none, [47:43] zero
    input  wire logic [stks_pkg::S_TDATA_W-1:0]       s_tdata,
    // [0] op
    input  wire logic                                 s_tuser,
    // result stream
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // [10:0] position, [11] found, [15:12] zero
    output logic [stks_pkg::M_TDATA_W-1:0]            m_tdata
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CMP_W  = (KEY_WIDTH + 1 > stks_pkg::TOL_W + 1) ?
                            KEY_WIDTH + 1 : stks_pkg::TOL_W + 1;
    localparam logic [KEY_WIDTH-1:0] KEY_SIGN = {1'b1, {(KEY_WIDTH-1){1'b0}}};

    localparam int POS_W   = stks_pkg::POS_W;
    localparam int COUNT_W = stks_pkg::COUNT_W;
    localparam int BOUND_W = stks_pkg::BOUND_W;

    // Input field unpack
    logic [stks_pkg::ENTRY_INDEX_W-1:0] in_entry_index;
    logic signed [stks_pkg::IN_KEY_W-1:0] in_key_value;
    logic                               in_miss_as_none;
    stks_pkg::op_t                      in_op;

    assign in_entry_index  = s_tdata[9:0];
    assign in_key_value    = s_tdata[41:10];
    assign in_miss_as_none = s_tdata[42];
    assign in_op           = stks_pkg::op_t'(s_tuser);

    // Configuration registers
    logic [COUNT_W-1:0]          key_count_reg;
    logic [stks_pkg::TOL_W-1:0]  match_tol_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_count_reg <= '0;
            match_tol_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                stks_pkg::CFG_KEY_COUNT: key_count_reg <= cfg_data[COUNT_W-1:0];
                stks_pkg::CFG_MATCH_TOL: match_tol_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer registers
    stks_pkg::state_t           state_reg, state_next;
    logic signed [BOUND_W-1:0]  s_reg, s_next;
    logic signed [BOUND_W-1:0]  e_reg, e_next;
    logic [POS_W-1:0]           m_reg, m_next;
    logic [COUNT_W-1:0]         count_reg, count_next;
    logic [KEY_WIDTH-1:0]       q_reg, q_next;
    logic                       none_reg, none_next;
    logic [POS_W-1:0]           res_pos_reg, res_pos_next;
    logic                       res_found_reg, res_found_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [POS_W-1:0]           out_pos_reg, out_pos_next;
    logic                       out_found_reg, out_found_next;

    // Table memory
    logic [KEY_WIDTH-1:0] key_table_reg [TABLE_DEPTH];
    logic [KEY_WIDTH-1:0] rdata_reg;
    logic                 rd_en;
    logic                 wr_en;

    // Load stores the key zero-extended; a query key is sign-extended
    logic [KEY_WIDTH-1:0]        load_key;
    logic signed [KEY_WIDTH-1:0] query_key;

    assign load_key  = KEY_WIDTH'(unsigned'(in_key_value));
    assign query_key = KEY_WIDTH'(in_key_value);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_table_reg[ADDR_W'(in_entry_index)] <= load_key;
        end
        if (rd_en) begin
            rdata_reg <= key_table_reg[ADDR_W'(m_next)];
        end
    end

    // Shared compare unit: offset-binary keys, gap against the tolerance
    logic [KEY_WIDTH-1:0] t_biased;
    logic                 q_gt;
    logic [CMP_W-1:0]     gap;
    logic                 far;

    assign t_biased = rdata_reg ^ KEY_SIGN;
    assign q_gt     = q_reg > t_biased;
    assign gap      = q_gt ? (CMP_W'(q_reg) - CMP_W'(t_biased))
                           : (CMP_W'(t_biased) - CMP_W'(q_reg));
    assign far      = gap > CMP_W'(match_tol_reg);

    // Next midpoints for both directions, formed alongside the compare
    logic [BOUND_W-1:0] sum_up;
    logic [BOUND_W-1:0] sum_dn;
    logic               up_cont;
    logic               dn_cont;

    assign sum_up  = BOUND_W'(m_reg) + BOUND_W'(1) + BOUND_W'(e_reg[POS_W-1:0]);
    assign sum_dn  = BOUND_W'(s_reg[POS_W-1:0]) + BOUND_W'(m_reg) - BOUND_W'(1);
    assign up_cont = $signed({1'b0, m_reg}) < e_reg;
    assign dn_cont = s_reg < $signed({1'b0, m_reg});

    // Query setup
    logic [COUNT_W-1:0] count_clamped;
    logic [COUNT_W-1:0] count_m1;

    assign count_clamped = (32'(key_count_reg) > TABLE_DEPTH) ? COUNT_W'(TABLE_DEPTH)
                                                               : key_count_reg;
    assign count_m1      = count_clamped - COUNT_W'(1);

    function automatic logic [POS_W-1:0] miss_pos(
        input logic                      none,
        input logic signed [BOUND_W-1:0] s_fin,
        input logic signed [BOUND_W-1:0] e_fin,
        input logic [COUNT_W-1:0]        count,
        input logic [POS_W-1:0]          m_last
    );
        logic [POS_W-1:0] pos;
        if (none) begin
            pos = stks_pkg::POS_NONE;
        end else if (e_fin < 0) begin
            pos = '0;
        end else if (s_fin < $signed({1'b0, count})) begin
            pos = s_fin[POS_W-1:0];
        end else begin
            pos = m_last;
        end
        return pos;
    endfunction

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        s_next         = s_reg;
        e_next         = e_reg;
        m_next         = m_reg;
        count_next     = count_reg;
        q_next         = q_reg;
        none_next      = none_reg;
        res_pos_next   = res_pos_reg;
        res_found_next = res_found_reg;
        out_pos_next   = out_pos_reg;
        out_found_next = out_found_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        s_tready       = 1'b0;

        unique case (state_reg)
            stks_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (in_op == stks_pkg::OP_LOAD) begin
                        wr_en = 32'(in_entry_index) < TABLE_DEPTH;
                    end else begin
                        q_next     = query_key ^ KEY_SIGN;
                        none_next  = in_miss_as_none;
                        count_next = count_clamped;
                        s_next     = '0;
                        e_next     = $signed({1'b0, count_clamped}) - BOUND_W'(1);
                        if (count_clamped == '0) begin
                            // empty table: no probe
                            m_next         = '0;
                            res_found_next = 1'b0;
                            res_pos_next   = in_miss_as_none ? stks_pkg::POS_NONE : '0;
                            state_next     = stks_pkg::ST_FINISH;
                        end else begin
                            m_next     = POS_W'(count_m1 >> 1);
                            rd_en      = 1'b1;
                            state_next = stks_pkg::ST_SEARCH;
                        end
                    end
                end
            end

            stks_pkg::ST_SEARCH: begin
                if (!far) begin
                    res_found_next = 1'b1;
                    res_pos_next   = m_reg;
                    state_next     = stks_pkg::ST_FINISH;
                end else if (q_gt) begin
                    s_next = $signed({1'b0, m_reg}) + BOUND_W'(1);
                    if (up_cont) begin
                        m_next = sum_up[BOUND_W-1:1];
                        rd_en  = 1'b1;
                    end else begin
                        res_found_next = 1'b0;
                        res_pos_next   = miss_pos(none_reg,
                                                  $signed({1'b0, m_reg}) + BOUND_W'(1),
                                                  e_reg, count_reg, m_reg);
                        state_next     = stks_pkg::ST_FINISH;
                    end
                end else begin
                    e_next = $signed({1'b0, m_reg}) - BOUND_W'(1);
                    if (dn_cont) begin
                        m_next = sum_dn[BOUND_W-1:1];
                        rd_en  = 1'b1;
                    end else begin
                        res_found_next = 1'b0;
                        res_pos_next   = miss_pos(none_reg, s_reg,
                                                  $signed({1'b0, m_reg}) - BOUND_W'(1),
                                                  count_reg, m_reg);
                        state_next     = stks_pkg::ST_FINISH;
                    end
                end
            end

            stks_pkg::ST_FINISH: begin
                if (out_free) begin
                    out_pos_next   = res_pos_reg;
                    out_found_next = res_found_reg;
                    m_tvalid_next  = 1'b1;
                    state_next     = stks_pkg::ST_IDLE;
                end
            end

            default: state_next = stks_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= stks_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        s_reg         <= s_next;
        e_reg         <= e_next;
        m_reg         <= m_next;
        count_reg     <= count_next;
        q_reg         <= q_next;
        none_reg      <= none_next;
        res_pos_reg   <= res_pos_next;
        res_found_reg <= res_found_next;
        out_pos_reg   <= out_pos_next;
        out_found_reg <= out_found_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(stks_pkg::M_TDATA_W-POS_W-1){1'b0}}, out_found_reg, out_pos_reg};

    // Search window stays ordered and holds the probe
    a_window_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == stks_pkg::ST_SEARCH |-> s_reg <= e_reg)
        else $error("search window inverted");

    a_probe_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == stks_pkg::ST_SEARCH |->
            ($signed({1'b0, m_reg}) >= s_reg) && ($signed({1'b0, m_reg}) <= e_reg))
        else $error("probe index outside search window");

    a_probe_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == stks_pkg::ST_SEARCH |-> m_reg < count_reg)
        else $error("probe index beyond entry count");

    a_finish_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == stks_pkg::ST_FINISH) && out_free |=>
            m_tvalid && (m_tdata[POS_W-1:0] == $past(res_pos_reg)))
        else $error("finished result not loaded into output register");

    a_hit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == stks_pkg::ST_FINISH) && res_found_reg |-> res_pos_reg < count_reg)
        else $error("hit position beyond entry count");

endmodule

`default_nettype wire

// ----- sim/sorted_table_key_search_tb.sv -----
`timescale 1ns / 100ps
// sorted_table_key_search_tb: self-checking bench for the sorted table key search block.
// Loads ascending key tables, runs tolerance searches and checks each result against a
// local binary-search predictor. Depends on stks_pkg and sorted_table_key_search.

module sorted_table_key_search_tb;

    localparam int DEPTH       = 1024;
    localparam int DRAIN_CYC   = 24;    // accept, the probes of a full table and output, with margin
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 40;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_LOAD,
        ROW_QUERY
    } row_kind_t;

    typedef struct {
        row_kind_t                  kind;
        stks_pkg::cfg_index_t       reg_sel;
        logic [15:0]                reg_val;
        logic [9:0]                 idx;
        logic [31:0]                key;
        bit                         none;
        bit                         fixed;
        logic [stks_pkg::POS_W-1:0] fpos;
        bit                         ffound;
    } dir_row_t;

    typedef struct {
        logic [stks_pkg::POS_W-1:0] pos;
        logic                       found;
    } search_answer_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [stks_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [stks_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [stks_pkg::S_TDATA_W-1:0]   s_tdata;
    logic                             s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [stks_pkg::M_TDATA_W-1:0]   m_tdata;

    // typed-in expectation travels with the query transfer
    logic                             fix_on;
    logic [stks_pkg::POS_W-1:0]       fix_pos;
    logic                             fix_found;

    // predictor state
    logic signed [31:0] key_tbl [DEPTH];
    int                 tbl_count;
    int                 tbl_tol;
    search_answer_t     answer_q [$];

    // stimulus side copy of the loaded keys
    logic signed [31:0] gen_keys [DEPTH];
    bit                 calm;
    int                 stall_left;

    int n_loads, n_queries, n_hits, n_checked, n_cfg, mismatches, idle_cycles;

    dir_row_t dir_rows [18];

    sorted_table_key_search dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Binary search with tolerance over the predictor's table copy.
    function automatic search_answer_t predict_search(logic signed [31:0] key, bit none);
        search_answer_t ans;
        int     n, lo, hi, mid;
        longint diff;
        bit     hit;
        n   = (tbl_count > DEPTH) ? DEPTH : tbl_count;
        lo  = 0;
        hi  = n - 1;
        mid = 0;
        hit = 1'b0;
        while (lo <= hi && !hit) begin
            mid  = (lo + hi) >> 1;
            diff = longint'(key) - longint'(key_tbl[mid]);
            if (diff > tbl_tol)
                lo = mid + 1;
            else if (-diff > tbl_tol)
                hi = mid - 1;
            else
                hit = 1'b1;
        end
        ans.found = hit;
        if (hit)
            ans.pos = mid[stks_pkg::POS_W-1:0];
        else if (none)
            ans.pos = stks_pkg::POS_NONE;
        else if (hi < 0)
            ans.pos = '0;
        else if (lo < n)
            ans.pos = lo[stks_pkg::POS_W-1:0];
        else
            ans.pos = mid[stks_pkg::POS_W-1:0];
        return ans;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Result side: monitor, predictor update and compare.
    always @(posedge aclk) begin : monitor
        search_answer_t exp_ans;
        logic [stks_pkg::POS_W-1:0] got_pos;
        logic                       got_found;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                n_cfg++;
                case (cfg_index)
                    stks_pkg::CFG_KEY_COUNT:
                        tbl_count = int'(cfg_data[stks_pkg::COUNT_W-1:0]);
                    stks_pkg::CFG_MATCH_TOL:
                        tbl_tol   = int'(cfg_data[stks_pkg::TOL_W-1:0]);
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got_pos   = m_tdata[stks_pkg::POS_W-1:0];
                got_found = m_tdata[stks_pkg::POS_W];
                if (answer_q.size() == 0) begin
                    mismatches++;
                    $error("result transfer with no query outstanding: position %0h found %0b",
                           got_pos, got_found);
                end else begin
                    exp_ans = answer_q.pop_front();
                    n_checked++;
                    if (got_pos !== exp_ans.pos) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $error("position: expected %0h, got %0h", exp_ans.pos, got_pos);
                    end
                    if (got_found !== exp_ans.found) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $error("found: expected %0b, got %0b", exp_ans.found, got_found);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == stks_pkg::OP_LOAD) begin
                    key_tbl[s_tdata[9:0]] = s_tdata[41:10];
                    n_loads++;
                end else begin
                    exp_ans = predict_search(s_tdata[41:10], s_tdata[42]);
                    if (fix_on) begin
                        exp_ans.pos   = fix_pos;
                        exp_ans.found = fix_found;
                    end
                    n_hits += exp_ans.found;
                    answer_q.push_back(exp_ans);
                    n_queries++;
                end
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (!calm && $urandom_range(0, 99) < 25) begin
            m_tready   <= 1'b0;
            stall_left = pick_gap();
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !aresetn)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("sorted_table_key_search_tb failed");
            $finish;
        end
    end

    task automatic send_item(stks_pkg::op_t op, logic [9:0] idx, logic [31:0] key, bit none,
                             bit fixed = 1'b0, logic [stks_pkg::POS_W-1:0] fpos = '0,
                             bit ffound = 1'b0);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= op;
        s_tdata   <= {5'b0, none, key, idx};
        fix_on    <= fixed;
        fix_pos   <= fpos;
        fix_found <= ffound;
        do @(posedge aclk); while (!s_tready);
    endtask

    // All results in and the sequencer drained before any register write.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (answer_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    task automatic write_cfg(stks_pkg::cfg_index_t sel, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Ascending keys with duplicates, tolerance-edge steps and wide jumps.
    task automatic fill_sorted(int n, int tol);
        longint cur;
        int     style, r;
        style = $urandom_range(0, 3);
        cur   = (style == 0) ? -64'sd2147483648 : longint'($signed($urandom()));
        if (style == 2)
            cur = cur / 4;
        for (int i = 0; i < n; i++) begin
            gen_keys[i] = cur[31:0];
            r = $urandom_range(0, 9);
            if (r < 2)
                cur += 0;
            else if (r < 4)
                cur += $urandom_range(1, 3);
            else if (r < 7)
                cur += tol + $urandom_range(0, 2);
            else
                cur += $urandom_range(0, 32'h003F_FFFF);
            if (cur > 64'sd2147483647)
                cur = 64'sd2147483647;
        end
        if (style == 3 && n > 0)
            gen_keys[n-1] = 32'h7FFF_FFFF;
    endtask

    function automatic logic [31:0] pick_query_key(int n, int tol);
        logic [31:0] base;
        int          r, off;
        base = gen_keys[$urandom_range(0, n - 1)];
        r    = $urandom_range(0, 99);
        if (r < 15)
            return base;
        else if (r < 45) begin
            off = int'($urandom_range(0, 2 * tol + 4)) - (tol + 2);
            return base + off;
        end else if (r < 65)
            return $urandom_range(0, 1) ? base + tol + 1 : base - tol - 1;
        else if (r < 88)
            return $urandom();
        else begin
            case ($urandom_range(0, 2))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                default: return 32'h0;
            endcase
        end
    endfunction

    task automatic run_phase(int count, bit reload, int n_q);
        int          n, tol, r;
        logic [9:0]  idx;
        logic [31:0] key;
        wait_idle();
        calm = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 3))
            0: tol = 0;
            1: tol = 65535;
            2: tol = $urandom_range(0, 16);
            default: tol = $urandom_range(0, 65535);
        endcase
        // upper bits of the count write are outside the register
        write_cfg(stks_pkg::CFG_KEY_COUNT, {5'($urandom()), 11'(count)});
        write_cfg(stks_pkg::CFG_MATCH_TOL, 16'(tol));
        n = (count > DEPTH) ? DEPTH : count;
        if (reload) begin
            fill_sorted(n, tol);
            for (int i = 0; i < n; i++)
                send_item(stks_pkg::OP_LOAD, 10'(i), gen_keys[i], 1'($urandom_range(0, 1)));
        end
        for (int q = 0; q < n_q; q++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                // stray load: past the counted entries, or one that breaks the order
                idx = 10'($urandom_range(0, DEPTH - 1));
                key = $urandom();
                if (idx < n)
                    gen_keys[idx] = key;
                send_item(stks_pkg::OP_LOAD, idx, key, 1'($urandom_range(0, 1)));
            end else begin
                key = (n == 0) ? $urandom() : pick_query_key(n, tol);
                send_item(stks_pkg::OP_QUERY, 10'($urandom()), key,
                          1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin : stimulus
        int count;
        aresetn    <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        s_tvalid   <= 1'b0;
        s_tuser    <= 1'b0;
        s_tdata    <= '0;
        fix_on     <= 1'b0;
        fix_pos    <= '0;
        fix_found  <= 1'b0;
        stall_left = 0;
        calm       = 1'b0;
        tbl_count  = 0;
        tbl_tol    = 0;
        n_loads = 0; n_queries = 0; n_hits = 0; n_checked = 0; n_cfg = 0;
        mismatches = 0; idle_cycles = 0;

        // kind, register, value, index, key, miss_as_none, typed, position, found
        dir_rows[0]  = '{ROW_QUERY, stks_pkg::CFG_KEY_COUNT, 16'd0, 10'd0, 32'h0000_0000,
                         1'b0, 1'b1, 11'd0, 1'b0};
        dir_rows[1]  = '{ROW_QUERY, stks_pkg::CFG_KEY_COUNT, 16'd0, 10'd0, 32'h0000_0000,
                         1'b1, 1'b1, stks_pkg::POS_NONE, 1'b0};
        dir_rows[2]  = '{ROW_CFG, stks_pkg::CFG_KEY_COUNT, 16'd4, 10'd0, 32'h0,
                         1'b0, 1'b0, 11'd0, 1'b0};
        dir_rows[3]  = '{ROW_CFG, stks_pkg::CFG_MATCH_TOL, 16'd0, 10'd0, 32'h0,
                         1'b0, 1'b0, 11'd0, 1'b0};
        dir_rows[4]  = '{ROW_LOAD, stks_pkg::CFG_KEY_COUNT, 16'd0, 10'd0, 32'h8000_0000,
                         1'b0, 1'b0, 11'd0, 1'b0};
        dir_rows[5]  = '{ROW_LOAD, stks_pkg::CFG_KEY_COUNT, 16'd0, 10'd1, 32'hFFFF_0000,
                         1'b1, 1'b0, 11'd0, 1'b0};
        dir_rows[6]  = '{ROW_LOAD, stks_pkg::CFG_KEY_COUNT, 16'd0, 10'd2, 32'h0001_0000,
                         1'b0, 1'b0, 11'd0, 1'b0};
        dir_rows[7]  = '{ROW_LOAD, stks_pkg::CFG_KEY_COUNT, 16'd0, 10'd3, 32'h7FFF_FFFF,
                         1'b0, 1'b0, 11'd0, 1'b0};
        dir_rows[8]  = '{ROW_QUERY, stks_pkg::CFG_KEY_COUNT, 16'd0, 10'd0, 32'h8000_0000,
                         1'b0, 1'b1, 11'd0, 1'b1};
        dir_rows[9]  = '{ROW_QUERY, stks_pkg::CFG_KEY_COUNT, 16'd0, 10'h3FF, 32'h7FFF_FFFF,
                         1'b1, 1'b1, 11'd3, 1'b1};
        dir_rows[10] = '{ROW_QUERY, stks_pkg::CFG_KEY_COUNT, 16'd0, 10'd0, 32'h0000_0000,
                         1'b1, 1'b1, stks_pkg::POS_NONE, 1'b0};
        // insertion position between entries, just below the maximum, just above the minimum
        dir_rows[11] = '{ROW_QUERY, stks_pkg::CFG_KEY_COUNT, 16'd0, 10'd0, 32'h0000_0000,
                         1'b0, 1'b0, 11'd0, 1'b0};
        dir_rows[12] = '{ROW_QUERY, stks_pkg::CFG_KEY_COUNT, 16'd0, 10'd0, 32'h7FFF_FFFE,
                         1'b0, 1'b0, 11'd0, 1'b0};
        dir_rows[13] = '{ROW_QUERY, stks_pkg::CFG_KEY_COUNT, 16'd0, 10'd0, 32'h8000_0001,
                         1'b0, 1'b0, 11'd0, 1'b0};
        dir_rows[14] = '{ROW_CFG, stks_pkg::CFG_MATCH_TOL, 16'hFFFF, 10'd0, 32'h0,
                         1'b0, 1'b0, 11'd0, 1'b0};
        dir_rows[15] = '{ROW_QUERY, stks_pkg::CFG_KEY_COUNT, 16'd0, 10'd0, 32'h0000_0001,
                         1'b0, 1'b0, 11'd0, 1'b0};
        dir_rows[16] = '{ROW_LOAD, stks_pkg::CFG_KEY_COUNT, 16'd0, 10'h3FF, 32'h5555_AAAA,
                         1'b1, 1'b0, 11'd0, 1'b0};
        dir_rows[17] = '{ROW_QUERY, stks_pkg::CFG_KEY_COUNT, 16'd0, 10'd0, 32'hFFFF_0001,
                         1'b1, 1'b0, 11'd0, 1'b0};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_CFG: begin
                    wait_idle();
                    write_cfg(dir_rows[i].reg_sel, dir_rows[i].reg_val);
                end
                ROW_LOAD:
                    send_item(stks_pkg::OP_LOAD, dir_rows[i].idx, dir_rows[i].key,
                              dir_rows[i].none);
                default:
                    send_item(stks_pkg::OP_QUERY, dir_rows[i].idx, dir_rows[i].key,
                              dir_rows[i].none, dir_rows[i].fixed, dir_rows[i].fpos,
                              dir_rows[i].ffound);
            endcase
        end

        // Random phases; phase 3 fills the whole table with an oversized count,
        // phase 4 reuses it at exactly full depth.
        for (int p = 0; p < 12; p++) begin
            if (p == 3)
                run_phase(2047, 1'b1, 100);
            else if (p == 4)
                run_phase(DEPTH, 1'b0, 100);
            else begin
                count = ($urandom_range(0, 9) == 0) ? 0 :
                        ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 48);
                run_phase(count, 1'b1, 90);
            end
        end

        wait_idle();
        $display("covered %0d loads, %0d queries (%0d hits), %0d register writes",
                 n_loads, n_queries, n_hits, n_cfg);
        $display("checked %0d results, %0d mismatches", n_checked, mismatches);
        if (mismatches == 0)
            $display("sorted_table_key_search_tb passed");
        else
            $display("sorted_table_key_search_tb failed");
        $finish;
    end

endmodule
